// File: sv/xorshift_permutation_stream_cipher_unit_defines.svh
`ifndef XORSHIFT_PERMUTATION_STREAM_CIPHER_UNIT_DEFINES_SVH
`define XORSHIFT_PERMUTATION_STREAM_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define XPSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xpsc: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define XPSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xpsc: next-cycle check failed");

`endif

// File: sv/xpsc_pkg.sv
package xpsc_pkg;

  localparam logic [31:0] SEED_MUL  = 32'h6C078965;
  localparam logic [31:0] GEN3_INIT = 32'h03DF95B3;
  localparam logic [31:0] SRC0_INIT = 32'h6C078966;
  localparam logic [31:0] SRC1_INIT = 32'hDD5254A5;
  localparam logic [31:0] SRC2_INIT = 32'hB9523B81;
  localparam logic [31:0] SRC3_INIT = 32'h03DF95B3;

  localparam logic [10:0] PRIME_ROM [256] = '{
    11'd3, 11'd5, 11'd7, 11'd11, 11'd13, 11'd17, 11'd19, 11'd23,
    11'd29, 11'd31, 11'd37, 11'd41, 11'd43, 11'd47, 11'd53, 11'd59,
    11'd61, 11'd67, 11'd71, 11'd73, 11'd79, 11'd83, 11'd89, 11'd97,
    11'd101, 11'd103, 11'd107, 11'd109, 11'd113, 11'd127, 11'd131, 11'd137,
    11'd139, 11'd149, 11'd151, 11'd157, 11'd163, 11'd167, 11'd173, 11'd179,
    11'd181, 11'd191, 11'd193, 11'd197, 11'd199, 11'd211, 11'd223, 11'd227,
    11'd229, 11'd233, 11'd239, 11'd241, 11'd251, 11'd257, 11'd263, 11'd269,
    11'd271, 11'd277, 11'd281, 11'd283, 11'd293, 11'd307, 11'd311, 11'd313,
    11'd317, 11'd331, 11'd337, 11'd347, 11'd349, 11'd353, 11'd359, 11'd367,
    11'd373, 11'd379, 11'd383, 11'd389, 11'd397, 11'd401, 11'd409, 11'd419,
    11'd421, 11'd431, 11'd433, 11'd439, 11'd443, 11'd449, 11'd457, 11'd461,
    11'd463, 11'd467, 11'd479, 11'd487, 11'd491, 11'd499, 11'd503, 11'd509,
    11'd521, 11'd523, 11'd541, 11'd547, 11'd557, 11'd563, 11'd569, 11'd571,
    11'd577, 11'd587, 11'd593, 11'd599, 11'd601, 11'd607, 11'd613, 11'd617,
    11'd619, 11'd631, 11'd641, 11'd643, 11'd647, 11'd653, 11'd659, 11'd661,
    11'd673, 11'd677, 11'd683, 11'd691, 11'd701, 11'd709, 11'd719, 11'd727,
    11'd733, 11'd739, 11'd743, 11'd751, 11'd757, 11'd761, 11'd769, 11'd773,
    11'd787, 11'd797, 11'd809, 11'd811, 11'd821, 11'd823, 11'd827, 11'd829,
    11'd839, 11'd853, 11'd857, 11'd859, 11'd863, 11'd877, 11'd881, 11'd883,
    11'd887, 11'd907, 11'd911, 11'd919, 11'd929, 11'd937, 11'd941, 11'd947,
    11'd953, 11'd967, 11'd971, 11'd977, 11'd983, 11'd991, 11'd997, 11'd1009,
    11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049, 11'd1051,
    11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097, 11'd1103,
    11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163, 11'd1171,
    11'd1181, 11'd1187, 11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223, 11'd1229,
    11'd1231, 11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279, 11'd1283, 11'd1289,
    11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307, 11'd1319, 11'd1321, 11'd1327,
    11'd1361, 11'd1367, 11'd1373, 11'd1381, 11'd1399, 11'd1409, 11'd1423, 11'd1427,
    11'd1429, 11'd1433, 11'd1439, 11'd1447, 11'd1451, 11'd1453, 11'd1459, 11'd1471,
    11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493, 11'd1499, 11'd1511, 11'd1523,
    11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571, 11'd1579,
    11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619, 11'd1621
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_INIT,
    ST_GEN,
    ST_RD2,
    ST_WR1,
    ST_WR2,
    ST_POSRD,
    ST_MUL,
    ST_KEYRD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RA_GEN_LO,
    RA_TBL_A,
    RA_POS_HI,
    RA_KEY
  } rda_sel_t;

  typedef enum logic {
    RB_GEN_HI,
    RB_TBL_B
  } rdb_sel_t;

  typedef enum logic {
    WR_A,
    WR_B
  } wr_sel_t;

  typedef struct packed {
    logic       accept;
    logic       seed_key;
    logic       draw;
    logic       init_en;
    logic [1:0] init_idx;
    logic       gen_step;
    logic       tbl_clr;
    logic       rd_en;
    rda_sel_t   rda_sel;
    rdb_sel_t   rdb_sel;
    logic       we;
    wr_sel_t    wr_sel;
    logic       mul_load;
    logic       out_load;
    logic       pos_clr;
  } cmd_t;

  typedef struct packed {
    logic in_first;
    logic key_zero;
    logic draw_nz;
    logic lo_zero;
    logic swap_eq;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] xs_step(input logic [31:0] s0, input logic [31:0] s3);
    logic [31:0] x;
    x = s0 ^ (s0 << 11);
    return x ^ (x >> 8) ^ s3 ^ (s3 >> 19);
  endfunction

endpackage

// File: sv/xpsc_if.sv
interface xpsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       first_of_message;

  modport source(output valid, output data_in, output first_of_message, input ready);
  modport sink(input valid, input data_in, input first_of_message, output ready);
endinterface

interface xpsc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic [31:0] used_seed;

  modport source(output valid, output data_out, output used_seed, input ready);
  modport sink(input valid, input data_out, input used_seed, output ready);
endinterface

interface xpsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_seed;

  modport source(output valid, output key_seed, input ready);
  modport sink(input valid, input key_seed, output ready);
endinterface

// File: sv/xpsc_tbl.sv
module xpsc_tbl (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clr,
  input  logic       rd_en,
  input  logic [7:0] ra,
  input  logic [7:0] rb,
  input  logic       we,
  input  logic [7:0] wa,
  input  logic [7:0] wd,
  output logic [7:0] da,
  output logic [7:0] db,
  output logic [7:0] addr_a,
  output logic [7:0] addr_b
);

  logic [7:0]   mem [256];
  logic [255:0] vld_r;
  logic [255:0] vld_nxt;
  logic [7:0]   qa_r;
  logic [7:0]   qb_r;
  logic [7:0]   ra_r;
  logic [7:0]   rb_r;
  logic         va_r;
  logic         vb_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      qa_r <= mem[ra];
      qb_r <= mem[rb];
      ra_r <= ra;
      rb_r <= rb;
      va_r <= vld_r[ra];
      vb_r <= vld_r[rb];
    end
  end

  // entries not yet written read as identity
  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (we) begin
      vld_nxt[wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign da     = va_r ? qa_r : ra_r;
  assign db     = vb_r ? qb_r : rb_r;
  assign addr_a = ra_r;
  assign addr_b = rb_r;

endmodule

// File: sv/xpsc_dp.sv
module xpsc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data,
  input  logic              in_first,
  input  xpsc_pkg::cmd_t    cmd,
  output xpsc_pkg::sts_t    sts,
  xpsc_out_if.source        out_chan,
  xpsc_cfg_if.sink          cfg_chan
);

  logic [31:0] key_r;
  logic [31:0] src_r [4];
  logic [31:0] gen_r [4];
  logic [31:0] act_r;
  logic [31:0] mix_r;
  logic [15:0] pos_r;
  logic [10:0] m_r;
  logic [7:0]  data_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic [31:0] out_seed_r;

  logic [31:0] src_new;
  logic [31:0] gen_new;
  logic [31:0] mix_x;
  logic [31:0] mix_val;
  logic [7:0]  lo_p1;
  logic [15:0] key_prod;
  logic [7:0]  key_idx;
  logic [7:0]  tbl_ra;
  logic [7:0]  tbl_rb;
  logic [7:0]  tbl_wa;
  logic [7:0]  tbl_wd;
  logic [7:0]  tbl_da;
  logic [7:0]  tbl_db;
  logic [7:0]  tbl_addr_a;
  logic [7:0]  tbl_addr_b;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_chan.valid) begin
      key_r <= cfg_chan.key_seed;
    end
  end

  assign src_new = xpsc_pkg::xs_step(src_r[0], src_r[3]);
  assign gen_new = xpsc_pkg::xs_step(gen_r[0], gen_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r[0] <= xpsc_pkg::SRC0_INIT;
      src_r[1] <= xpsc_pkg::SRC1_INIT;
      src_r[2] <= xpsc_pkg::SRC2_INIT;
      src_r[3] <= xpsc_pkg::SRC3_INIT;
    end else if (cmd.draw) begin
      src_r[0] <= src_r[1];
      src_r[1] <= src_r[2];
      src_r[2] <= src_r[3];
      src_r[3] <= src_new;
    end
  end

  // seed expansion, one multiply per cycle
  assign mix_x   = mix_r ^ (mix_r >> 30);
  assign mix_val = xpsc_pkg::SEED_MUL * mix_x + 32'(cmd.init_idx) + 32'd1;

  always_ff @(posedge clk) begin
    if (cmd.seed_key) begin
      mix_r <= key_r;
    end else if (cmd.draw) begin
      mix_r <= src_new;
    end else if (cmd.init_en) begin
      mix_r <= mix_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (cmd.seed_key) begin
      act_r <= key_r;
    end else if (cmd.draw && (src_new != 32'd0)) begin
      act_r <= src_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_en) begin
      case (cmd.init_idx)
        2'd0: begin
          gen_r[0] <= mix_val;
          gen_r[3] <= xpsc_pkg::GEN3_INIT;
        end
        2'd1: gen_r[1] <= mix_val;
        2'd2: gen_r[2] <= mix_val;
        default: gen_r[3] <= xpsc_pkg::GEN3_INIT;
      endcase
    end else if (cmd.gen_step) begin
      gen_r[0] <= gen_r[1];
      gen_r[1] <= gen_r[2];
      gen_r[2] <= gen_r[3];
      gen_r[3] <= gen_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      m_r   <= '0;
    end else begin
      if (cmd.pos_clr) begin
        pos_r <= '0;
      end else if (cmd.out_load) begin
        pos_r <= pos_r + 16'd1;
      end
      if (cmd.mul_load) begin
        m_r <= xpsc_pkg::PRIME_ROM[tbl_da];
      end
    end
  end

  assign lo_p1    = pos_r[7:0] + 8'd1;
  assign key_prod = {8'd0, lo_p1} * {8'd0, m_r[7:0]};
  assign key_idx  = key_prod[7:0];

  always_comb begin
    case (cmd.rda_sel)
      xpsc_pkg::RA_GEN_LO: tbl_ra = gen_new[7:0];
      xpsc_pkg::RA_TBL_A:  tbl_ra = tbl_da;
      xpsc_pkg::RA_POS_HI: tbl_ra = pos_r[15:8];
      xpsc_pkg::RA_KEY:    tbl_ra = key_idx;
      default:             tbl_ra = key_idx;
    endcase
    case (cmd.rdb_sel)
      xpsc_pkg::RB_GEN_HI: tbl_rb = gen_new[15:8];
      xpsc_pkg::RB_TBL_B:  tbl_rb = tbl_db;
      default:             tbl_rb = tbl_db;
    endcase
    case (cmd.wr_sel)
      xpsc_pkg::WR_A: begin
        tbl_wa = tbl_addr_a;
        tbl_wd = tbl_db;
      end
      xpsc_pkg::WR_B: begin
        tbl_wa = tbl_addr_b;
        tbl_wd = tbl_da;
      end
      default: begin
        tbl_wa = tbl_addr_b;
        tbl_wd = tbl_da;
      end
    endcase
  end

  xpsc_tbl u_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (cmd.tbl_clr),
    .rd_en  (cmd.rd_en),
    .ra     (tbl_ra),
    .rb     (tbl_rb),
    .we     (cmd.we),
    .wa     (tbl_wa),
    .wd     (tbl_wd),
    .da     (tbl_da),
    .db     (tbl_db),
    .addr_a (tbl_addr_a),
    .addr_b (tbl_addr_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= data_r ^ tbl_da;
      out_seed_r <= act_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.data_out  = out_data_r;
  assign out_chan.used_seed = out_seed_r;

  assign sts.in_first = in_first;
  assign sts.key_zero = (key_r == 32'd0);
  assign sts.draw_nz  = (src_new != 32'd0);
  assign sts.lo_zero  = (pos_r[7:0] == 8'd0);
  assign sts.swap_eq  = (tbl_addr_a == tbl_addr_b);
  assign sts.out_free = !out_valid_r || out_chan.ready;

endmodule

// File: sv/xpsc_ctrl.sv
module xpsc_ctrl #(
  parameter int SWAP_ROUNDS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  xpsc_pkg::sts_t   sts,
  output xpsc_pkg::cmd_t   cmd
);

  localparam int RW = $clog2(SWAP_ROUNDS + 1);

  xpsc_pkg::state_t state_r;
  xpsc_pkg::state_t state_nxt;
  logic [1:0]       icnt_r;
  logic [1:0]       icnt_nxt;
  logic [RW-1:0]    round_r;
  logic [RW-1:0]    round_nxt;
  logic             last_round;

  assign last_round = (round_r == RW'(SWAP_ROUNDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xpsc_pkg::ST_IDLE;
      icnt_r  <= '0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      icnt_r  <= icnt_nxt;
      round_r <= round_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    icnt_nxt  = icnt_r;
    round_nxt = round_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      xpsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_first) begin
            cmd.pos_clr = 1'b1;
            cmd.tbl_clr = 1'b1;
            icnt_nxt    = '0;
            if (sts.key_zero) begin
              state_nxt = xpsc_pkg::ST_DRAW;
            end else begin
              cmd.seed_key = 1'b1;
              state_nxt    = xpsc_pkg::ST_INIT;
            end
          end else if (sts.lo_zero) begin
            cmd.rd_en   = 1'b1;
            cmd.rda_sel = xpsc_pkg::RA_POS_HI;
            state_nxt   = xpsc_pkg::ST_MUL;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rda_sel = xpsc_pkg::RA_KEY;
            state_nxt   = xpsc_pkg::ST_OUT;
          end
        end
      end
      xpsc_pkg::ST_DRAW: begin
        cmd.draw = 1'b1;
        if (sts.draw_nz) begin
          state_nxt = xpsc_pkg::ST_INIT;
        end
      end
      xpsc_pkg::ST_INIT: begin
        cmd.init_en  = 1'b1;
        cmd.init_idx = icnt_r;
        if (icnt_r == 2'd2) begin
          round_nxt = '0;
          state_nxt = xpsc_pkg::ST_GEN;
        end else begin
          icnt_nxt = icnt_r + 2'd1;
        end
      end
      xpsc_pkg::ST_GEN: begin
        cmd.gen_step = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rda_sel  = xpsc_pkg::RA_GEN_LO;
        cmd.rdb_sel  = xpsc_pkg::RB_GEN_HI;
        state_nxt    = xpsc_pkg::ST_RD2;
      end
      xpsc_pkg::ST_RD2: begin
        if (sts.swap_eq) begin
          round_nxt = round_r + RW'(1);
          if (last_round) begin
            cmd.rd_en   = 1'b1;
            cmd.rda_sel = xpsc_pkg::RA_POS_HI;
            state_nxt   = xpsc_pkg::ST_MUL;
          end else begin
            state_nxt = xpsc_pkg::ST_GEN;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rda_sel = xpsc_pkg::RA_TBL_A;
          cmd.rdb_sel = xpsc_pkg::RB_TBL_B;
          state_nxt   = xpsc_pkg::ST_WR1;
        end
      end
      xpsc_pkg::ST_WR1: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = xpsc_pkg::WR_A;
        state_nxt  = xpsc_pkg::ST_WR2;
      end
      xpsc_pkg::ST_WR2: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = xpsc_pkg::WR_B;
        round_nxt  = round_r + RW'(1);
        if (last_round) begin
          state_nxt = xpsc_pkg::ST_POSRD;
        end else begin
          state_nxt = xpsc_pkg::ST_GEN;
        end
      end
      // multiplier lookup once the last swap is written
      xpsc_pkg::ST_POSRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rda_sel = xpsc_pkg::RA_POS_HI;
        state_nxt   = xpsc_pkg::ST_MUL;
      end
      xpsc_pkg::ST_MUL: begin
        if (!cmd.we) begin
          cmd.mul_load = 1'b1;
        end
        state_nxt = xpsc_pkg::ST_KEYRD;
      end
      xpsc_pkg::ST_KEYRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rda_sel = xpsc_pkg::RA_KEY;
        state_nxt   = xpsc_pkg::ST_OUT;
      end
      xpsc_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = xpsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xpsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/xorshift_permutation_stream_cipher_unit.sv
// Byte stream cipher; encrypt and decrypt are the same operation.
// in_chan carries data_in and first_of_message, out_chan returns data_out
// and used_seed, one result per input byte, in order. cfg_chan writes
// key_seed (zero draws a nonzero seed from the internal seed source); the
// user must write it only while the block is idle; no check enforces it.
// A byte with first_of_message set rekeys first: seed draws for a zero
// key_seed, seed expansion into three generator words, then SWAP_ROUNDS
// swap rounds, each with two table reads and two writes on the single
// write port of the 256-entry table unless its indexes are equal.
// A data byte is accepted with its key-index table read and its result
// is registered in the OUT state; at each 256-byte block boundary the
// multiplier lookup adds the MUL and KEYRD states. One byte is in work at
// a time; the next byte is taken as soon as its result is registered.
// The result register holds while out_chan.ready is low; the block then
// waits with in_chan.ready low after finishing the following byte.
// Reset sets the table to identity, position, multiplier and seed to zero
// and restores the seed source; no clearing pass is needed.
`include "xorshift_permutation_stream_cipher_unit_defines.svh"

module xorshift_permutation_stream_cipher_unit #(
  parameter int SWAP_ROUNDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  xpsc_in_if.sink     in_chan,
  xpsc_out_if.source  out_chan,
  xpsc_cfg_if.sink    cfg_chan
);

  xpsc_pkg::cmd_t cmd;
  xpsc_pkg::sts_t sts;
  logic           in_ready;

  assign in_chan.ready = in_ready;

  xpsc_ctrl #(
    .SWAP_ROUNDS (SWAP_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xpsc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_chan.data_in),
    .in_first (in_chan.first_of_message),
    .cmd      (cmd),
    .sts      (sts),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  `XPSC_ASSERT_NXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  `XPSC_ASSERT_IMP(a_no_swap_while_ready, cmd.we, !in_chan.ready)
  `XPSC_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_chan.valid || out_chan.ready)
  `XPSC_ASSERT_NXT(a_out_hold, out_chan.valid && !out_chan.ready, out_chan.valid && $stable(out_chan.data_out))

endmodule

// File: verif/xorshift_permutation_stream_cipher_unit_tb.sv
`timescale 1ns / 100ps

module xorshift_permutation_stream_cipher_unit_tb;

  localparam int SWAP_ROUNDS = 4096;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [31:0] SEED_SCRAMBLE = 32'h6C078965;
  localparam logic [31:0] GEN_TAIL      = 32'h03DF95B3;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } cipher_in_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [31:0] used_seed;
  } cipher_out_t;

  logic clk;
  logic rst_n;

  xpsc_in_if  in_if ();
  xpsc_out_if out_if ();
  xpsc_cfg_if cfg_if ();

  xorshift_permutation_stream_cipher_unit #(
    .SWAP_ROUNDS(SWAP_ROUNDS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // predictor state
  logic [3:0][31:0] seed_pool;
  logic [3:0][31:0] shuffle_gen;
  logic [7:0]       perm [256];
  logic [15:0]      byte_pos;
  logic [10:0]      block_mul;
  logic [31:0]      msg_seed;
  logic [31:0]      key_seed_shadow;
  logic [10:0]      odd_primes [256];

  cipher_in_t  byte_q [$];
  cipher_out_t expected_bytes [$];
  cipher_in_t  cur_byte;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int mismatches = 0;
  int bytes_in = 0;
  int bytes_out = 0;
  int rekeys = 0;
  int key_writes = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  bit hold_arm = 0;
  bit hold_used = 0;

  function automatic logic [3:0][31:0] xs_shift(input logic [3:0][31:0] s);
    logic [31:0] x;
    x = s[0] ^ (s[0] << 11);
    return {x ^ (x >> 8) ^ s[3] ^ (s[3] >> 19), s[3], s[2], s[1]};
  endfunction

  function automatic void fill_primes();
    int n;
    int cnt;
    bit is_p;
    cnt = 0;
    n = 3;
    while (cnt < 256) begin
      is_p = 1;
      for (int d = 3; d * d <= n; d += 2) begin
        if (n % d == 0) is_p = 0;
      end
      if (is_p) begin
        odd_primes[cnt] = 11'(n);
        cnt++;
      end
      n += 2;
    end
  endfunction

  function automatic void rebuild_table();
    logic [31:0] s;
    logic [7:0]  lo, hi, a, b, t;
    s = key_seed_shadow;
    while (s == 32'd0) begin
      seed_pool = xs_shift(seed_pool);
      s = seed_pool[3];
    end
    msg_seed = s;
    shuffle_gen[0] = SEED_SCRAMBLE * (s ^ (s >> 30)) + 32'd1;
    shuffle_gen[1] = SEED_SCRAMBLE * (shuffle_gen[0] ^ (shuffle_gen[0] >> 30)) + 32'd2;
    shuffle_gen[2] = SEED_SCRAMBLE * (shuffle_gen[1] ^ (shuffle_gen[1] >> 30)) + 32'd3;
    shuffle_gen[3] = GEN_TAIL;
    for (int i = 0; i < 256; i++) perm[i] = 8'(i);
    for (int i = 0; i < SWAP_ROUNDS; i++) begin
      shuffle_gen = xs_shift(shuffle_gen);
      lo = shuffle_gen[3][7:0];
      hi = shuffle_gen[3][15:8];
      if (lo != hi) begin
        a = perm[lo];
        b = perm[hi];
        t = perm[a];
        perm[a] = perm[b];
        perm[b] = t;
      end
    end
    byte_pos = 16'd0;
  endfunction

  function automatic cipher_out_t cipher_byte(input cipher_in_t b);
    cipher_out_t r;
    int unsigned k;
    if (b.first) rebuild_table();
    if (byte_pos[7:0] == 8'd0) block_mul = odd_primes[perm[byte_pos[15:8]]];
    k = ((32'(byte_pos[7:0]) + 32'd1) * 32'(block_mul)) & 32'hFF;
    r.data_out = b.data ^ perm[k[7:0]];
    r.used_seed = msg_seed;
    byte_pos = byte_pos + 16'd1;
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic first);
    cipher_in_t b;
    b.data = data;
    b.first = first;
    byte_q.push_back(b);
  endfunction

  task automatic queue_messages(input int n_items);
    int left;
    int len;
    bit cont;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(257, 520) : $urandom_range(1, 80);
      // now and then carry on the previous message without a rekey
      cont = ($urandom_range(7) == 0);
      for (int j = 0; j < len; j++) begin
        push_byte(8'($urandom_range(255)),
                  (j == 0 && !cont) || ($urandom_range(399) == 0));
      end
      left -= len;
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_if.valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key(input logic [31:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.key_seed <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    key_seed_shadow = v;
    key_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data_in <= 8'd0;
      in_if.first_of_message <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_bytes.push_back(cipher_byte(cur_byte));
        bytes_in++;
        if (cur_byte.first) rekeys++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_byte = byte_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.data_in <= cur_byte.data;
          in_if.first_of_message <= cur_byte.first;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    cipher_out_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_out++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: data_out %h used_seed %h",
                 out_if.data_out, out_if.used_seed);
          mismatches++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_if.data_out !== e.data_out) begin
            $error("data_out mismatch: expected %h, got %h", e.data_out, out_if.data_out);
            mismatches++;
          end
          if (out_if.used_seed !== e.used_seed) begin
            $error("used_seed mismatch: expected %h, got %h", e.used_seed, out_if.used_seed);
            mismatches++;
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready && hold_arm && !hold_used) begin
        hold_cnt <= HOLD_CYCLES;
        hold_used <= 1'b1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.key_seed <= 32'd0;

    fill_primes();
    seed_pool = {32'h03DF95B3, 32'hB9523B81, 32'hDD5254A5, 32'h6C078966};
    shuffle_gen = '0;
    for (int i = 0; i < 256; i++) perm[i] = 8'(i);
    byte_pos = 16'd0;
    block_mul = 11'd0;
    msg_seed = 32'd0;
    key_seed_shadow = 32'd0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    snd_idle_pct = 9;
    rcv_idle_pct = 59;

    // zero seed, bytes before any rekey, then two drawn seeds
    write_key(32'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b0);
    drain();

    write_key(32'hFFFF_FFFF);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h3C, 1'b1);
    drain();

    write_key(32'd1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    drain();

    write_key($urandom());
    queue_messages(500);
    drain();

    snd_idle_pct = 59;
    rcv_idle_pct = 9;
    write_key(32'd0);
    queue_messages(500);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_key($urandom());
    hold_arm = 1'b1;
    queue_messages(500);
    drain();

    repeat (20) @(posedge clk);
    $display("run covered %0d bytes in, %0d out, %0d rekeys, %0d key_seed writes",
             bytes_in, bytes_out, rekeys, key_writes);
    $display("long receiver hold %0s", hold_used ? "done" : "missed");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
